// File: src/crr_pkg.sv
`default_nettype none

package crr_pkg;

    // Table geometry
    localparam int ENTRIES     = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int DEV_W    = 8;
    localparam int HANDLE_W = 64;
    localparam int EPOCH_W  = 64;
    localparam int STATUS_W = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [IDX_W-1:0]       idx_t;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_BEGIN_SUB    = 2'd0,
        MODE_END_SUB      = 2'd1,
        MODE_BEGIN_RETIRE = 2'd2,
        MODE_RETIRE       = 2'd3
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_RETIRING    = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_MISSING     = 3'd3,
        ST_UNDERFLOW   = 3'd4,
        ST_ACTIVE      = 3'd5,
        ST_NOT_STARTED = 3'd6,
        ST_FULL        = 3'd7
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;   // capture the incoming item
        logic do_match;  // key match and free-slot search
        logic do_exec;   // read-modify-write and result load
    } crr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_full;  // result register holds an item not yet taken
    } crr_sts_t;

endpackage

`default_nettype wire

// File: src/crr_ctrl.sv
`default_nettype none

module crr_ctrl
    import crr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic     out_stall,
    input  wire crr_sts_t sts,
    output crr_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec_go;
    logic   take;

    // Execute only when the result register is free or being emptied
    assign exec_go  = (state_reg == S_EXEC) && (!sts.out_full || !out_stall);
    assign in_stall = !((state_reg == S_IDLE) || exec_go);
    assign take     = in_valid && !in_stall;

    assign cmd.load_in  = take;
    assign cmd.do_match = (state_reg == S_MATCH);
    assign cmd.do_exec  = exec_go;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = take ? S_MATCH : S_IDLE;
            S_MATCH: state_next = S_EXEC;
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = take ? S_MATCH : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/crr_datapath.sv
`default_nettype none

module crr_datapath
    import crr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crr_cmd_t            cmd,
    output crr_sts_t                 sts,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [DEV_W-1:0]    dev_num,
    input  wire logic [HANDLE_W-1:0] context_handle,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     accepted,
    output logic [EPOCH_W-1:0]       epoch,
    output logic [STATUS_W-1:0]      status,
    output logic                     created
);

    // Captured item
    logic [MODE_W-1:0]   mode_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // Table storage
    logic [ENTRIES-1:0]  valid_reg;
    logic [DEV_W-1:0]    dev_tab_reg    [ENTRIES];
    logic [HANDLE_W-1:0] handle_tab_reg [ENTRIES];
    count_t              count_tab_reg  [ENTRIES];
    logic [ENTRIES-1:0]  retiring_reg;
    logic [EPOCH_W-1:0]  epoch_tab_reg  [ENTRIES];
    logic [EPOCH_W-1:0]  epoch_ctr_reg;
    logic [EPOCH_W-1:0]  epoch_ctr_next;

    // Match stage results
    logic hit_reg,  hit_next;
    idx_t slot_reg, slot_next;
    logic free_ok_reg, free_ok_next;
    idx_t free_reg, free_next;

    // Result register
    logic                out_valid_reg;
    logic                accepted_reg, accepted_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [STATUS_W-1:0] status_reg;
    status_t             status_next;
    logic                created_reg, created_next;

    // Execute stage signals
    idx_t               sel;
    count_t             cur_count;
    logic               cur_ret;
    logic [EPOCH_W-1:0] new_epoch;
    logic               wr_new;
    logic               wr_count;
    count_t             count_new;
    logic               set_ret;
    logic               clr_valid;

    // Parallel key match and lowest free slot
    always_comb
    begin
        hit_next     = 1'b0;
        slot_next    = '0;
        free_ok_next = 1'b0;
        free_next    = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && dev_tab_reg[i] == dev_reg
                && handle_tab_reg[i] == handle_reg)
            begin
                hit_next  = 1'b1;
                slot_next = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok_next = 1'b1;
                free_next    = IDX_W'(i);
            end
        end
    end

    // Epoch issue skips zero
    assign new_epoch      = (epoch_ctr_reg == '0) ? EPOCH_W'(1) : epoch_ctr_reg;
    assign epoch_ctr_next = (epoch_ctr_reg == '0) ? EPOCH_W'(2) : epoch_ctr_reg + EPOCH_W'(1);

    // Entry read at the selected slot
    assign sel       = hit_reg ? slot_reg : free_reg;
    assign cur_count = hit_reg ? count_tab_reg[slot_reg] : '0;
    assign cur_ret   = hit_reg ? retiring_reg[slot_reg] : 1'b0;

    // Operation decode
    always_comb
    begin
        accepted_next = 1'b0;
        epoch_next    = '0;
        status_next   = ST_OK;
        created_next  = 1'b0;
        wr_new        = 1'b0;
        wr_count      = 1'b0;
        count_new     = cur_count;
        set_ret       = 1'b0;
        clr_valid     = 1'b0;
        case (mode_t'(mode_reg))
            MODE_BEGIN_SUB:
            begin
                if (!hit_reg && !free_ok_reg)
                begin
                    status_next = ST_FULL;
                end
                else if (cur_ret)
                begin
                    status_next = ST_RETIRING;
                end
                else if (cur_count == '1)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_new        = !hit_reg;
                    wr_count      = 1'b1;
                    count_new     = cur_count + COUNT_WIDTH'(1);
                    accepted_next = 1'b1;
                    created_next  = !hit_reg;
                    epoch_next    = hit_reg ? epoch_tab_reg[slot_reg] : new_epoch;
                end
            end
            MODE_END_SUB:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_MISSING;
                end
                else if (cur_count == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    wr_count      = 1'b1;
                    count_new     = cur_count - COUNT_WIDTH'(1);
                    accepted_next = 1'b1;
                end
            end
            MODE_BEGIN_RETIRE:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_MISSING;
                end
                else if (cur_count != '0)
                begin
                    status_next = ST_ACTIVE;
                end
                else
                begin
                    set_ret       = 1'b1;
                    accepted_next = 1'b1;
                    epoch_next    = epoch_tab_reg[slot_reg];
                end
            end
            MODE_RETIRE:
            begin
                if (!hit_reg)
                begin
                    accepted_next = 1'b1;
                end
                else if (cur_count != '0)
                begin
                    status_next = ST_ACTIVE;
                end
                else if (!cur_ret)
                begin
                    status_next = ST_NOT_STARTED;
                end
                else
                begin
                    clr_valid     = 1'b1;
                    accepted_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Item capture and match results
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode;
            dev_reg    <= dev_num;
            handle_reg <= context_handle;
        end
        if (cmd.do_match)
        begin
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            free_ok_reg <= free_ok_next;
            free_reg    <= free_next;
        end
    end

    // Table payload, written at the selected slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.do_exec && sel == IDX_W'(i))
            begin
                if (wr_new)
                begin
                    dev_tab_reg[i]    <= dev_reg;
                    handle_tab_reg[i] <= handle_reg;
                    epoch_tab_reg[i]  <= new_epoch;
                end
                if (wr_count)
                begin
                    count_tab_reg[i] <= count_new;
                end
                if (wr_new || set_ret)
                begin
                    retiring_reg[i] <= set_ret;
                end
            end
        end
    end

    // Valid bits and epoch counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            epoch_ctr_reg <= EPOCH_W'(1);
        end
        else if (cmd.do_exec)
        begin
            if (wr_new)
            begin
                valid_reg[sel] <= 1'b1;
                epoch_ctr_reg  <= epoch_ctr_next;
            end
            else if (clr_valid)
            begin
                valid_reg[sel] <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_exec)
        begin
            accepted_reg <= accepted_next;
            epoch_reg    <= epoch_next;
            status_reg   <= status_next;
            created_reg  <= created_next;
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign epoch        = epoch_reg;
    assign status       = status_reg;
    assign created      = created_reg;

endmodule

`default_nettype wire

// File: src/context_refcount_registry_top.sv
// Context reference-count registry. Each request (mode, dev_num,
// context_handle) gives exactly one result (accepted, epoch, status, created)
// in request order. A request passes a match step, the parallel key match
// over all ENTRIES table slots plus the lowest-free-slot search, and then a
// write step, the read-modify-write of the selected entry, which also loads the
// result register. A new request is taken in the same cycle that the previous
// one writes its result, so no request is taken while one is in its match step;
// the write step waits while the result register holds an untaken result.
// The table resets empty at once (per-entry valid flops, no clearing pass)
// and the epoch counter resets to one.
`default_nettype none

module context_refcount_registry_top
    import crr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [DEV_W-1:0]    dev_num,
    input  wire logic [HANDLE_W-1:0] context_handle,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     accepted,
    output logic [EPOCH_W-1:0]       epoch,
    output logic [STATUS_W-1:0]      status,
    output logic                     created
);

    crr_cmd_t cmd;
    crr_sts_t sts;

    crr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    crr_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .dev_num        (dev_num),
        .context_handle (context_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .epoch          (epoch),
        .status         (status),
        .created        (created)
    );

endmodule

`default_nettype wire

// File: src/crr_checker.sv
`default_nettype none

module crr_checker
    import crr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic [MODE_W-1:0]   mode,
    input wire logic [DEV_W-1:0]    dev_num,
    input wire logic [HANDLE_W-1:0] context_handle,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic                accepted,
    input wire logic [EPOCH_W-1:0]  epoch,
    input wire logic [STATUS_W-1:0] status,
    input wire logic                created
);

    // Accept and ok status go together
    a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (status == ST_OK)))
        else $error("accepted flag disagrees with status");

    // Rejected items carry no epoch and no creation
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (epoch == '0 && !created))
        else $error("rejected item has epoch or created set");

    // A created entry always gets a nonzero epoch
    a_created_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && created) |-> (accepted && epoch != '0))
        else $error("created item without accept or epoch");

    // The match step follows every accepted item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item taken in match cycle");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(accepted) && $stable(epoch)
            && $stable(status) && $stable(created)))
        else $error("stalled result changed");

endmodule

bind context_refcount_registry_top crr_checker u_crr_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import crr_pkg::*;

    localparam int N_KEYS       = 20;
    localparam int PHASE_ITEMS  = 325;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        mode_t                mode;
        logic [DEV_W-1:0]     dev;
        logic [HANDLE_W-1:0]  handle;
    } request_t;

    typedef struct {
        logic                 accepted;
        logic [EPOCH_W-1:0]   epoch;
        status_t              status;
        logic                 created;
    } outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode           = '0;
    logic [DEV_W-1:0]     dev_num        = '0;
    logic [HANDLE_W-1:0]  context_handle = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 accepted;
    logic [EPOCH_W-1:0]   epoch;
    logic [STATUS_W-1:0]  status;
    logic                 created;

    request_t  pending_req_q[$];
    outcome_t  expected_outcome_q[$];
    request_t  cur_req;
    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        err_count = 0;
    int        cycle_count = 0;

    // key pool and per-key lifecycle plans
    logic [DEV_W-1:0]     key_dev[N_KEYS];
    logic [HANDLE_W-1:0]  key_handle[N_KEYS];
    mode_t                plan_q[N_KEYS][$];

    // predicted registry contents
    logic                 ctx_valid[ENTRIES];
    logic [DEV_W-1:0]     ctx_dev[ENTRIES];
    logic [HANDLE_W-1:0]  ctx_handle[ENTRIES];
    count_t               ctx_count[ENTRIES];
    logic                 ctx_retiring[ENTRIES];
    logic [EPOCH_W-1:0]   ctx_epoch[ENTRIES];
    logic [EPOCH_W-1:0]   epoch_ctr;

    context_refcount_registry_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .dev_num        (dev_num),
        .context_handle (context_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .epoch          (epoch),
        .status         (status),
        .created        (created)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hand out the next epoch; zero is never issued
    function automatic logic [EPOCH_W-1:0] issue_epoch();
        logic [EPOCH_W-1:0] e;
        e = epoch_ctr;
        epoch_ctr = epoch_ctr + 1'b1;
        if (e == '0)
        begin
            e = epoch_ctr;
            epoch_ctr = epoch_ctr + 1'b1;
        end
        return e;
    endfunction

    // apply one request to the predicted table and return its result
    function automatic outcome_t apply_context_op(input request_t rq);
        outcome_t r;
        int       slot;
        int       free_slot;
        r.accepted = 1'b0;
        r.epoch    = '0;
        r.status   = ST_OK;
        r.created  = 1'b0;
        slot       = -1;
        free_slot  = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (ctx_valid[i] && ctx_dev[i] == rq.dev && ctx_handle[i] == rq.handle)
                slot = i;
            if (!ctx_valid[i])
                free_slot = i;
        end
        case (rq.mode)
            MODE_BEGIN_SUB:
            begin
                if (slot < 0 && free_slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    if (slot < 0)
                    begin
                        slot               = free_slot;
                        ctx_valid[slot]    = 1'b1;
                        ctx_dev[slot]      = rq.dev;
                        ctx_handle[slot]   = rq.handle;
                        ctx_count[slot]    = '0;
                        ctx_retiring[slot] = 1'b0;
                        ctx_epoch[slot]    = issue_epoch();
                        r.created          = 1'b1;
                    end
                    if (ctx_retiring[slot])
                    begin
                        r.status  = ST_RETIRING;
                        r.created = 1'b0;
                    end
                    else if (ctx_count[slot] == {COUNT_WIDTH{1'b1}})
                    begin
                        r.status  = ST_OVERFLOW;
                        r.created = 1'b0;
                    end
                    else
                    begin
                        ctx_count[slot] = ctx_count[slot] + 1'b1;
                        r.epoch         = ctx_epoch[slot];
                        r.accepted      = 1'b1;
                    end
                end
            end
            MODE_END_SUB:
            begin
                if (slot < 0)
                    r.status = ST_MISSING;
                else if (ctx_count[slot] == '0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    ctx_count[slot] = ctx_count[slot] - 1'b1;
                    r.accepted      = 1'b1;
                end
            end
            MODE_BEGIN_RETIRE:
            begin
                if (slot < 0)
                    r.status = ST_MISSING;
                else if (ctx_count[slot] != '0)
                    r.status = ST_ACTIVE;
                else
                begin
                    ctx_retiring[slot] = 1'b1;
                    r.epoch            = ctx_epoch[slot];
                    r.accepted         = 1'b1;
                end
            end
            default:
            begin
                if (slot < 0)
                    r.accepted = 1'b1;
                else if (ctx_count[slot] != '0)
                    r.status = ST_ACTIVE;
                else if (!ctx_retiring[slot])
                    r.status = ST_NOT_STARTED;
                else
                begin
                    ctx_valid[slot] = 1'b0;
                    r.accepted      = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        err_count++;
    endtask

    task automatic queue_item(input mode_t m, input int k);
        request_t rq;
        rq.mode   = m;
        rq.dev    = key_dev[k];
        rq.handle = key_handle[k];
        pending_req_q = {pending_req_q, rq};
    endtask

    // lifecycles on pooled keys interleaved at random, plus noise
    task automatic gen_random(input int n);
        int       k;
        int       depth;
        request_t rq;
        for (int made = 0; made < n; made++)
        begin
            if ($urandom_range(99) < 10)
            begin
                rq.mode   = mode_t'($urandom_range(3));
                rq.dev    = DEV_W'($urandom);
                rq.handle = {$urandom, $urandom};
                pending_req_q = {pending_req_q, rq};
            end
            else
            begin
                k = $urandom_range(N_KEYS - 1);
                if (plan_q[k].size() == 0)
                begin
                    if ($urandom_range(99) < 75)
                    begin
                        // extra ends drain any count left by broken plans
                        depth = $urandom_range(1, 5);
                        repeat (depth) plan_q[k] = {plan_q[k], MODE_BEGIN_SUB};
                        repeat (depth + 2) plan_q[k] = {plan_q[k], MODE_END_SUB};
                        plan_q[k] = {plan_q[k], MODE_BEGIN_RETIRE};
                        plan_q[k] = {plan_q[k], MODE_RETIRE};
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 3))
                            plan_q[k] = {plan_q[k], mode_t'($urandom_range(3))};
                    end
                end
                queue_item(plan_q[k].pop_front(), k);
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_req_q.size() > 0 || expected_outcome_q.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            mode           <= MODE_BEGIN_SUB;
            dev_num        <= '0;
            context_handle <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_outcome_q = {expected_outcome_q, apply_context_op(cur_req)};
            if (!in_valid || !in_stall)
            begin
                if (pending_req_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_req         = pending_req_q.pop_front();
                    in_valid       <= 1'b1;
                    mode           <= cur_req.mode;
                    dev_num        <= cur_req.dev;
                    context_handle <= cur_req.handle;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and result check
    always @(posedge clk or negedge rst_n)
    begin : result_mon
        outcome_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outcome_q.size() == 0)
                begin
                    $display("[%0t] result with nothing outstanding", $time);
                    err_count++;
                end
                else
                begin
                    want = expected_outcome_q.pop_front();
                    if (accepted !== want.accepted)
                        report_mismatch("accepted", 64'(accepted), 64'(want.accepted));
                    if (epoch !== want.epoch)
                        report_mismatch("epoch", epoch, want.epoch);
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (created !== want.created)
                        report_mismatch("created", 64'(created), 64'(want.created));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ctx_valid[i]    = 1'b0;
            ctx_dev[i]      = '0;
            ctx_handle[i]   = '0;
            ctx_count[i]    = '0;
            ctx_retiring[i] = 1'b0;
            ctx_epoch[i]    = '0;
        end
        epoch_ctr = 1;

        // key pool: two extreme keys, the rest random
        key_dev[0]    = '1;
        key_handle[0] = '1;
        key_dev[1]    = '0;
        key_handle[1] = '0;
        for (int i = 2; i < N_KEYS; i++)
        begin
            key_dev[i]    = DEV_W'($urandom);
            key_handle[i] = {$urandom, $urandom};
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: missing key handling
        queue_item(MODE_RETIRE, 1);
        queue_item(MODE_END_SUB, 1);
        queue_item(MODE_BEGIN_RETIRE, 1);
        // fill the table, then request one key more than it holds
        for (int k = 0; k <= ENTRIES; k++)
            queue_item(MODE_BEGIN_SUB, k);
        // second submission, busy entry refusals
        queue_item(MODE_BEGIN_SUB, 0);
        queue_item(MODE_BEGIN_RETIRE, 0);
        queue_item(MODE_RETIRE, 0);
        // underflow, retire before begin retire, repeated begin retire,
        // submission on a retiring entry, removal
        queue_item(MODE_END_SUB, 1);
        queue_item(MODE_END_SUB, 1);
        queue_item(MODE_RETIRE, 1);
        queue_item(MODE_BEGIN_RETIRE, 1);
        queue_item(MODE_BEGIN_RETIRE, 1);
        queue_item(MODE_BEGIN_SUB, 1);
        queue_item(MODE_RETIRE, 1);
        wait_quiet();

        // random phases with different idling and output stalling
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            gen_random(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
